// ===== src/tesl_pkg.sv =====
package tesl_pkg;

  localparam int unsigned IN_W    = 16;
  localparam int unsigned E_W     = IN_W + 1;
  localparam int unsigned P_W     = 2 * E_W;
  localparam int unsigned N_W     = P_W + 3;
  localparam int unsigned DP_W    = E_W + N_W;
  localparam int unsigned DET_W   = DP_W + 2;
  localparam int unsigned ADET_W  = DET_W;
  localparam int unsigned DOT_W   = 2 * N_W + 2;
  localparam int unsigned K_W     = 32;
  localparam int unsigned LOAD_W  = 31;
  localparam int unsigned IN_DATA_W  = 12 * IN_W;
  localparam int unsigned OUT_DATA_W = 168;

  localparam logic [K_W-1:0] LIM_POS = 32'h7FFF_FFFF;
  localparam logic [K_W-1:0] LIM_NEG = 32'h8000_0000;
  localparam int unsigned LOAD_DIV   = 24;

  typedef struct packed {
    logic [3:0][2:0][N_W-1:0] n;
    logic [ADET_W-1:0]        adet;
    logic                     degen;
  } elem_t;

  typedef struct packed {
    logic [1:0]            row;
    logic [3:0][K_W-1:0]   k;
    logic [LOAD_W-1:0]     load;
    logic                  degen;
    logic                  last;
  } res_t;

endpackage

// ===== src/tesl_front.sv =====
module tesl_front import tesl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [IN_DATA_W-1:0] in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output elem_t                out_elem_o
);

  logic adv;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  logic signed [2:0][2:0][E_W-1:0]       e_d;
  logic        [2:0][2:0][E_W-1:0]       e_q;
  logic        [2:0][2:0][1:0][P_W-1:0]  pp_d;
  logic        [2:0][2:0][1:0][P_W-1:0]  pp_q;
  logic        [2:0][E_W-1:0]            e0b_q, e0c_q;
  logic        [2:0][2:0][N_W-1:0]       n_d;
  logic        [2:0][2:0][N_W-1:0]       n_q;
  logic        [3:0][2:0][N_W-1:0]       nd_d;
  logic        [3:0][2:0][N_W-1:0]       nd_q;
  logic        [2:0][DP_W-1:0]           dp_d;
  logic        [2:0][DP_W-1:0]           dp_q;
  logic signed [DET_W-1:0]               det;
  elem_t                                 elem_d, elem_q;

  assign adv        = !ve_q || out_ready_i;
  assign in_ready_o = adv;

  for (genvar i = 0; i < 3; i++) begin : g_edge
    for (genvar c = 0; c < 3; c++) begin : g_comp
      assign e_d[i][c] = E_W'($signed(in_data_i[((i + 1) * 3 + c) * IN_W +: IN_W]))
                       - E_W'($signed(in_data_i[c * IN_W +: IN_W]));
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int unsigned KA = (k + 1) % 3;
    localparam int unsigned KB = (k + 2) % 3;
    for (genvar c = 0; c < 3; c++) begin : g_comp
      localparam int unsigned C1 = (c + 1) % 3;
      localparam int unsigned C2 = (c + 2) % 3;
      assign pp_d[k][c][0] = P_W'($signed(e_q[KA][C1]) * $signed(e_q[KB][C2]));
      assign pp_d[k][c][1] = P_W'($signed(e_q[KA][C2]) * $signed(e_q[KB][C1]));
      assign n_d[k][c] = N_W'($signed(pp_q[k][c][0])) - N_W'($signed(pp_q[k][c][1]));
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_det
    assign nd_d[0][c] = -($signed(n_q[0][c]) + $signed(n_q[1][c]) + $signed(n_q[2][c]));
    assign nd_d[1][c] = n_q[0][c];
    assign nd_d[2][c] = n_q[1][c];
    assign nd_d[3][c] = n_q[2][c];
    assign dp_d[c]    = DP_W'($signed(e0c_q[c]) * $signed(n_q[0][c]));
  end

  always_comb begin
    det = DET_W'($signed(dp_q[0])) + DET_W'($signed(dp_q[1]))
        + DET_W'($signed(dp_q[2]));
    elem_d.n     = nd_q;
    elem_d.adet  = det[DET_W-1] ? ADET_W'(-det) : ADET_W'(det);
    elem_d.degen = (det == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_q    <= e_d;
      pp_q   <= pp_d;
      e0b_q  <= e_q[0];
      e0c_q  <= e0b_q;
      n_q    <= n_d;
      nd_q   <= nd_d;
      dp_q   <= dp_d;
      elem_q <= elem_d;
    end
  end

  assign out_valid_o = ve_q;
  assign out_elem_o  = elem_q;

endmodule

// ===== src/tesl_fifo.sv =====
module tesl_fifo import tesl_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  input  elem_t wr_elem_i,
  output logic  rd_valid_o,
  input  logic  rd_ready_i,
  output elem_t rd_elem_o
);

  elem_t      mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_elem_o  = mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem[wr_ptr_q] <= wr_elem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/tesl_div.sv =====
module tesl_div import tesl_pkg::*; #(
  parameter int unsigned NUM_W = 100,
  parameter int unsigned DEN_W = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [K_W-1:0]   limit_i,
  output logic             done_o,
  output logic [K_W-1:0]   q_o
);

  localparam int unsigned CMP_W = (NUM_W > DEN_W + K_W) ? NUM_W : DEN_W + K_W;

  logic [CMP_W-1:0] r_q, ds_q;
  logic [K_W-1:0]   q_q, lim_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q, ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && cnt_q == 5'd0) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      r_q   <= CMP_W'(num_i);
      ds_q  <= CMP_W'(den_i) << (K_W - 1);
      ovf_q <= CMP_W'(num_i) >= (CMP_W'(den_i) << K_W);
      lim_q <= limit_i;
      q_q   <= '0;
      cnt_q <= 5'd31;
    end else if (busy_q) begin
      if (r_q >= ds_q) begin
        r_q        <= r_q - ds_q;
        q_q[cnt_q] <= 1'b1;
      end
      ds_q  <= ds_q >> 1;
      cnt_q <= cnt_q - 5'd1;
    end
  end

  assign done_o = done_q;
  assign q_o    = (ovf_q || q_q > lim_q) ? lim_q : q_q;

endmodule

// ===== src/tesl_back.sv =====
module tesl_back import tesl_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 8,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  elem_t in_elem_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  out_res_o
);

  localparam int SK  = RESULT_FRAC_BITS - COORD_FRAC_BITS;
  localparam int SL  = RESULT_FRAC_BITS - 3 * COORD_FRAC_BITS;
  localparam int unsigned SKP = (SK > 0) ? SK : 0;
  localparam int unsigned SKN = (SK < 0) ? -SK : 0;
  localparam int unsigned SLP = (SL > 0) ? SL : 0;
  localparam int unsigned SLN = (SL < 0) ? -SL : 0;
  localparam int unsigned D6_W   = ADET_W + 3;
  localparam int unsigned NKA    = DOT_W + SKP + 1;
  localparam int unsigned NKB    = D6_W + SKN;
  localparam int unsigned NUMK_W = ((NKA > NKB) ? NKA : NKB) + 1;
  localparam int unsigned DENK_W = D6_W + SKN + 1;
  localparam int unsigned NLA    = ADET_W + SLP + 1;
  localparam int unsigned NLB    = 5 + SLN;
  localparam int unsigned NUML_W = ((NLA > NLB) ? NLA : NLB) + 1;
  localparam int unsigned LY_W   = 33;
  localparam int unsigned LP_W   = 67;

  // divide by 48 as a shift by 4 and a reciprocal multiply by 1/3
  localparam logic [33:0]       LOAD_RECIP3 = 34'd11453246123;
  localparam logic [NUML_W-1:0] LY_LIM      = NUML_W'(64'd6442450944);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DOT  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] st_q, st_d;
  logic [1:0] row_q;
  elem_t      elem_q;
  logic       out_valid_q;
  res_t       res_q;

  logic [3:0][2:0][2*N_W-1:0] prod_q;
  logic [3:0][DOT_W-1:0]      dot_q;
  logic [3:0][DOT_W-1:0]      mag;
  logic [3:0][NUMK_W-1:0]     num_k;
  logic [DENK_W-1:0]          den_k;
  logic [D6_W-1:0]            den6;
  logic [NUML_W-1:0]          num_l;
  logic [NUML_W-1:0]          ly_full;
  logic [LP_W-1:0]            lprod;
  logic [K_W-1:0]             lq_q;
  logic [3:0]                 neg_q;
  logic [3:0]                 kdone;
  logic [3:0][K_W-1:0]        kq;
  logic                       start_k, slot_free;

  assign in_ready_o = (st_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;
  assign start_k    = (st_q == ST_DIV);

  assign den6  = (D6_W'(elem_q.adet) << 2) + (D6_W'(elem_q.adet) << 1);
  assign den_k = DENK_W'(den6) << (SKN + 1);
  assign num_l = (NUML_W'(elem_q.adet) << (SLP + 1)) + (NUML_W'(LOAD_DIV) << SLN);
  assign ly_full = num_l >> (SLN + 4);
  assign lprod   = ly_full[LY_W-1:0] * LOAD_RECIP3;

  for (genvar j = 0; j < 4; j++) begin : g_col
    assign mag[j]   = dot_q[j][DOT_W-1] ? DOT_W'(-dot_q[j]) : dot_q[j];
    assign num_k[j] = (NUMK_W'(mag[j]) << (SKP + 1)) + (NUMK_W'(den6) << SKN);

    tesl_div #(
      .NUM_W (NUMK_W),
      .DEN_W (DENK_W)
    ) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (start_k),
      .num_i   (num_k[j]),
      .den_i   (den_k),
      .limit_i (dot_q[j][DOT_W-1] ? LIM_NEG : LIM_POS),
      .done_o  (kdone[j]),
      .q_o     (kq[j])
    );
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: if (in_valid_i) st_d = ST_DOT;
      ST_DOT:  st_d = ST_SUM;
      ST_SUM:  st_d = ST_DIV;
      ST_DIV:  st_d = ST_WAIT;
      ST_WAIT: if (&kdone) st_d = ST_OUT;
      ST_OUT: begin
        if (slot_free) st_d = (row_q == 2'd3) ? ST_IDLE : ST_DOT;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      row_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == ST_IDLE) row_q <= 2'd0;
      else if (st_q == ST_OUT && slot_free) row_q <= row_q + 2'd1;
      if (st_q == ST_OUT && slot_free) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && in_valid_i) elem_q <= in_elem_i;
    if (st_q == ST_DOT) begin
      for (int j = 0; j < 4; j++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[j][c] <= (2*N_W)'($signed(elem_q.n[row_q][c]) * $signed(elem_q.n[j][c]));
        end
      end
    end
    if (st_q == ST_SUM) begin
      for (int j = 0; j < 4; j++) begin
        dot_q[j] <= DOT_W'($signed(prod_q[j][0])) + DOT_W'($signed(prod_q[j][1]))
                  + DOT_W'($signed(prod_q[j][2]));
      end
    end
    if (st_q == ST_DIV) begin
      for (int j = 0; j < 4; j++) neg_q[j] <= dot_q[j][DOT_W-1];
      lq_q <= (ly_full >= LY_LIM) ? LIM_POS : lprod[LP_W-1:35];
    end
    if (st_q == ST_OUT && slot_free) begin
      res_q.row   <= row_q;
      res_q.degen <= elem_q.degen;
      res_q.last  <= (row_q == 2'd3);
      res_q.load  <= elem_q.degen ? '0 : lq_q[LOAD_W-1:0];
      for (int j = 0; j < 4; j++) begin
        res_q.k[j] <= elem_q.degen ? '0 : (neg_q[j] ? K_W'(-kq[j]) : kq[j]);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== src/tet_element_stiffness_load_top.sv =====
// Datapath: each input transaction passes the 5 geometry stages, a two-entry queue and
// the evaluation sequencer, which sends the four rows in order as the output takes them.
// The sequencer accepts a new element only once all four rows of the last are out; the
// 32-step restoring dividers, one per column, are shared across the four rows.
// The geometry pipeline and a two-entry queue accept new elements meanwhile.
// Reset clears all valid flags, queue pointers and sequencer state.
module tet_element_stiffness_load_top import tesl_pkg::*; #(
  parameter int COORD_FRAC_BITS  = 8,
  parameter int RESULT_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // ax, ay, az, bx, by, bz, cx, cy, cz, dx, dy, dz, 16 bits each
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // row[1:0], k_col0, k_col1, k_col2, k_col3 (32 each), load (31), zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // degenerate
  output logic                  m_axis_tuser_o,
  output logic                  m_axis_tlast_o
);

  logic  fr_valid, fr_ready, bk_valid, bk_ready;
  elem_t fr_elem, bk_elem;
  res_t  res;

  tesl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_elem_o  (fr_elem)
  );

  tesl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_elem_i  (fr_elem),
    .rd_valid_o (bk_valid),
    .rd_ready_i (bk_ready),
    .rd_elem_o  (bk_elem)
  );

  tesl_back #(
    .COORD_FRAC_BITS  (COORD_FRAC_BITS),
    .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_elem_i   (bk_elem),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res)
  );

  assign m_axis_tdata_o = {7'b0, res.load, res.k[3], res.k[2], res.k[1], res.k[0], res.row};
  assign m_axis_tuser_o = res.degen;
  assign m_axis_tlast_o = res.last;

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == (m_axis_tdata_o[1:0] == 2'd3)))
    else $error("tlast does not match row index");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[160:2] == '0))
    else $error("degenerate element with nonzero entries");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) ##1 m_axis_tvalid_o
    |-> m_axis_tdata_o[1:0] == $past(m_axis_tdata_o[1:0]) + 2'd1)
    else $error("row index skipped");

endmodule
